// ===== rtl/core/tavd_pkg.sv =====
// Shared types, constants and the arctangent table of the tilt angle detector.
`timescale 1ns / 1ps

package tavd_pkg;

  // Field widths of the beats.
  localparam int ANGLE_W = 16;
  localparam int ACCEL_W = 16;

  // Default averaging window length.
  localparam int WINDOW_LENGTH_DEF = 16;

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_IDX_W = 5;
  localparam int VEC_W        = 36;
  localparam int ACC_W        = 26;
  localparam int ATAN_W       = 22;
  localparam int PROD_W       = 63;
  localparam int GAIN_W       = 30;

  // Reciprocal of the CORDIC gain in Q30.
  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
  // Ninety degrees in 1/65536 degree.
  localparam logic signed [ACC_W-1:0] DEG90_Q16 = 26'sd5898240;
  // 180 degrees in 1/256 degree.
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 16'd46080;
  // Ten degrees in 1/256 degree.
  localparam logic [ANGLE_W-1:0] THRESHOLD_RESET = 16'd2560;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
  } tavd_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] tilt_angle;
    logic [ANGLE_W-1:0] average_angle;
    logic               vertical;
  } tavd_out_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [CORDIC_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/tilt_angle_vertical_detector.sv =====
// Top level of the tilt angle detector: CORDIC angle, windowed average, vertical flag.
`timescale 1ns / 1ps
// Only one sample is in flight: the block takes a new sample only after the result beat of
// the last one has gone into the result register. Each sample passes through the shared
// CORDIC unit (two passes of 20 iterations) and the bit-serial divider of the average, one
// quotient bit a cycle, SUM_W = 16 + clog2(WINDOW_LENGTH) quotient bits in all.
// Reset (rst_n low at a clock edge, synchronous) empties the window and the result
// register and loads the threshold with ten degrees; the window memory needs no clearing.

module tilt_angle_vertical_detector
  import tavd_pkg::*;
#(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration: the vertical threshold in 1/256 degree.
  input  logic               cfg_we,
  input  logic [ANGLE_W-1:0] cfg_wdata,
  // Sample channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  tavd_in_t           in_data,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output tavd_out_t          out_data
);

  // Slot index, fill count and running sum widths all follow the window length.
  localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W  = ANGLE_W + $clog2(WINDOW_LENGTH);
  localparam int STEP_W = $clog2((SUM_W > CORDIC_STEPS) ? SUM_W : CORDIC_STEPS);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_LENGTH);
  localparam logic [STEP_W-1:0] LAST_ITER = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_DIV  = STEP_W'(SUM_W - 1);

  // The sequencer walks one sample through these phases:
  //   S_VEC1  CORDIC vectoring on (|y|, z) gives the horizontal magnitude times the gain.
  //   S_MULH, S_MULL  gain correction as two 16/17 by 30 bit partial products.
  //   S_PREP  loads the second vector (x, r), pre-rotated by -90 degrees when x < 0.
  //   S_VEC2  CORDIC vectoring again, this time accumulating the angle.
  //   S_FIN   rounds the angle, updates the window memory, sum and fill count.
  //   S_DIV   restoring division of the rounded sum by the fill count.
  //   S_DONE  hands the beat to the result register once that register is free.
  typedef enum logic [3:0] {
    S_IDLE,
    S_VEC1,
    S_MULH,
    S_MULL,
    S_PREP,
    S_VEC2,
    S_FIN,
    S_DIV,
    S_DONE
  } state_t;

  state_t                    state_r;
  logic [STEP_W-1:0]         step_r;
  logic signed [VEC_W-1:0]   u_r;
  logic signed [VEC_W-1:0]   v_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACCEL_W-1:0] x_r;
  logic                      zero_r;
  logic [PROD_W-1:0]         prod_r;
  logic [SUM_W-1:0]          sum_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [ANGLE_W-1:0]        thr_r;
  logic [ANGLE_W-1:0]        angle_r;
  logic [SUM_W-1:0]          dq_r;
  logic [CNT_W-1:0]          rem_r;
  logic [ANGLE_W-1:0]        rd_data_r;
  logic                      out_valid_r;
  tavd_out_t                 out_data_r;

  // Window of past angles: one write port, one registered read port.
  logic [ANGLE_W-1:0] win_mem [WINDOW_LENGTH];

  logic                      in_fire;
  logic                      mem_re;
  logic                      mem_we;

  // Shared CORDIC iteration.
  logic signed [VEC_W-1:0]   du;
  logic signed [VEC_W-1:0]   dv;
  logic signed [ACC_W-1:0]   atan_step;
  logic signed [VEC_W-1:0]   u_nxt;
  logic signed [VEC_W-1:0]   v_nxt;
  logic signed [ACC_W-1:0]   acc_nxt;

  // Start values of the two vectoring passes.
  logic signed [ACCEL_W:0]   y_ext;
  logic signed [ACCEL_W:0]   y_abs;
  logic signed [VEC_W-1:0]   u_start;
  logic signed [VEC_W-1:0]   v_start;
  logic signed [VEC_W-1:0]   x_scaled;
  logic signed [VEC_W-1:0]   r_vec;

  // Rounding, window update and divider.
  logic signed [ACC_W-1:0]   acc_rnd;
  logic [ANGLE_W-1:0]        angle_nxt;
  logic [ANGLE_W-1:0]        old_angle;
  logic [SUM_W-1:0]          sum_nxt;
  logic [CNT_W-1:0]          cnt_nxt;
  logic [CNT_W:0]            rem_sh;
  logic                      q_bit;
  logic [CNT_W-1:0]          rem_nxt;
  logic [SUM_W-1:0]          dq_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The slot about to be overwritten is read when the sample is accepted, so the old
  // angle sits in rd_data_r long before S_FIN writes the same slot. Only one sample is
  // in flight, so a read and a write of the same slot never overlap.
  assign mem_re = in_fire;
  assign mem_we = (state_r == S_FIN);

  // One vectoring iteration: rotate toward the positive u axis, floor shifts.
  always_comb begin
    du        = v_r >>> step_r;
    dv        = u_r >>> step_r;
    atan_step = ACC_W'($signed({1'b0, atan_q16(step_r[CORDIC_IDX_W-1:0])}));
    if (!v_r[VEC_W-1]) begin
      u_nxt   = u_r + du;
      v_nxt   = v_r - dv;
      acc_nxt = acc_r + atan_step;
    end else begin
      u_nxt   = u_r - du;
      v_nxt   = v_r + dv;
      acc_nxt = acc_r - atan_step;
    end
  end

  // First pass starts from (|y|, z) in Q16; |y| of the most negative sample needs 17 bits.
  always_comb begin
    y_ext   = (ACCEL_W + 1)'(in_data.accel_y);
    y_abs   = y_ext[ACCEL_W] ? -y_ext : y_ext;
    u_start = VEC_W'(y_abs) <<< 16;
    v_start = VEC_W'(in_data.accel_z) <<< 16;
  end

  // Second pass: x in Q16, and the gain-corrected magnitude r = floor(prod / 2^30).
  // The first pass never makes u negative and keeps it below 2^33.
  always_comb begin
    x_scaled = VEC_W'(x_r) <<< 16;
    r_vec    = VEC_W'({1'b0, prod_r[PROD_W-1:GAIN_W]});
  end

  // Round the Q16 angle to 1/256 degree and clamp it to 0..180 degrees. The all-zero
  // sample is forced to zero, as atan2(0, 0) is.
  always_comb begin
    acc_rnd = (acc_r + ACC_W'(128)) >>> 8;
    if (zero_r || acc_rnd[ACC_W-1]) begin
      angle_nxt = '0;
    end else if (acc_rnd > ACC_W'(ANGLE_MAX)) begin
      angle_nxt = ANGLE_MAX;
    end else begin
      angle_nxt = acc_rnd[ANGLE_W-1:0];
    end
  end

  // Slots fill in order from zero, so until the window is full the slot being replaced
  // holds no angle of the current window and counts as zero.
  always_comb begin
    old_angle = (cnt_r == FULL_CNT) ? rd_data_r : '0;
    sum_nxt   = sum_r - SUM_W'(old_angle) + SUM_W'(angle_nxt);
    cnt_nxt   = (cnt_r == FULL_CNT) ? cnt_r : cnt_r + CNT_W'(1);
  end

  // Restoring division step: the quotient bit shifts into dq_r as the dividend leaves.
  always_comb begin
    rem_sh  = {rem_r, dq_r[SUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, cnt_r});
    rem_nxt = q_bit ? CNT_W'(rem_sh - {1'b0, cnt_r}) : CNT_W'(rem_sh);
    dq_nxt  = {dq_r[SUM_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[slot_r] <= angle_nxt;
    end
    if (mem_re) begin
      rd_data_r <= win_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      slot_r      <= '0;
      thr_r       <= THRESHOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end

      // The result register drains independently of the sequencer. In S_DONE a beat
      // leaving the register is replaced by the new one in the same cycle.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            u_r     <= u_start;
            v_r     <= v_start;
            acc_r   <= '0;
            x_r     <= in_data.accel_x;
            zero_r  <= (in_data.accel_x == '0) && (in_data.accel_y == '0) &&
                       (in_data.accel_z == '0);
            step_r  <= '0;
            state_r <= S_VEC1;
          end
        end
        S_VEC1: begin
          u_r   <= u_nxt;
          v_r   <= v_nxt;
          acc_r <= acc_nxt;
          if (step_r == LAST_ITER) begin
            step_r  <= '0;
            state_r <= S_MULH;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_MULH: begin
          prod_r  <= {47'd0, u_r[32:17]} * {33'd0, INV_GAIN_Q30};
          state_r <= S_MULL;
        end
        S_MULL: begin
          prod_r  <= (prod_r << 17) + ({46'd0, u_r[16:0]} * {33'd0, INV_GAIN_Q30});
          state_r <= S_PREP;
        end
        S_PREP: begin
          if (x_r[ACCEL_W-1]) begin
            u_r   <= r_vec;
            v_r   <= -x_scaled;
            acc_r <= DEG90_Q16;
          end else begin
            u_r   <= x_scaled;
            v_r   <= r_vec;
            acc_r <= '0;
          end
          step_r  <= '0;
          state_r <= S_VEC2;
        end
        S_VEC2: begin
          u_r   <= u_nxt;
          v_r   <= v_nxt;
          acc_r <= acc_nxt;
          if (step_r == LAST_ITER) begin
            step_r  <= '0;
            state_r <= S_FIN;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_FIN: begin
          angle_r <= angle_nxt;
          sum_r   <= sum_nxt;
          cnt_r   <= cnt_nxt;
          slot_r  <= (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
          // Round to nearest: add half the divisor before dividing.
          dq_r    <= sum_nxt + SUM_W'(cnt_nxt >> 1);
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          if (step_r == LAST_DIV) begin
            step_r  <= '0;
            state_r <= S_DONE;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_DONE: begin
          // The average never exceeds 180 degrees, so its low bits hold the quotient.
          if (!out_valid_r || out_ready) begin
            out_data_r.tilt_angle    <= angle_r;
            out_data_r.average_angle <= dq_r[ANGLE_W-1:0];
            out_data_r.vertical      <= (dq_r[ANGLE_W-1:0] < thr_r);
            out_valid_r              <= 1'b1;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tavd_checker.sv =====
// Port-level checker of the tilt angle detector and its bind to the top level.
`timescale 1ns / 1ps

module tavd_checker
  import tavd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input tavd_out_t out_data
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Only one sample is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample accepted while one is in flight");

  // Angles and averages stay within 0..180 degrees.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tilt_angle <= ANGLE_MAX) &&
                  (out_data.average_angle <= ANGLE_MAX))
    else $error("angle out of range");

  // Reset empties the result register and opens the input.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the block");

endmodule

bind tilt_angle_vertical_detector tavd_checker u_tavd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tilt_angle_vertical_detector_tb.sv =====
// Self-checking testbench for the tilt angle vertical detector: directed table, then random samples.
`timescale 1ns / 1ps

module tilt_angle_vertical_detector_tb
  import tavd_pkg::*;
();

  // The run is cut off here. The slowest correct run is near 550 beats, each with the
  // longest sender gap, its pass through the block and the longest receiver stall.
  localparam int CYCLE_LIMIT = 1000000;
  // Cycles to let pass once the last result beat has come in.
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PER_PHASE = 88;
  localparam int NUM_PHASES = 6;
  localparam int HIST_DEPTH = 16;
  localparam int MAX_PRINTED = 30;

  // Fixed-point constants of the angle computation.
  localparam longint INV_GAIN_Q30_C = 652032874;
  localparam longint QUARTER_TURN_Q16 = 5898240;
  localparam longint HALF_TURN_Q8 = 46080;

  typedef enum int {
    STY_UNIFORM,
    STY_UPRIGHT,
    STY_TINY,
    STY_INVERTED,
    STY_ONE_AXIS
  } sample_style_t;

  // One row of the directed table. When has_want is set the row carries its
  // own expected result beat; otherwise the predictor supplies it.
  typedef struct {
    tavd_in_t  sample;
    bit        has_want;
    tavd_out_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [ANGLE_W-1:0] cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  tavd_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  tavd_out_t out_data;

  tilt_angle_vertical_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // atan(2^-i) in 1/65536 degree for the twenty CORDIC micro-rotations.
  longint atan_step [0:19] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  // Mirror of the block's averaging state and its threshold register.
  logic [ANGLE_W-1:0] angle_hist [HIST_DEPTH];
  int                 hist_sum;
  int                 hist_count;
  int                 hist_slot;
  logic [ANGLE_W-1:0] threshold_q8;

  // Result beats still owed by the block, oldest first.
  tavd_out_t pending_results [$];
  stim_row_t directed_rows [$];

  int        error_count = 0;
  int        cycle_count = 0;
  int        samples_sent;
  int        results_checked = 0;
  int        vertical_seen = 0;
  tavd_out_t got_beat;
  tavd_out_t want_beat;
  logic [ANGLE_W-1:0] phase_thresholds [NUM_PHASES];
  sample_style_t      style;
  int                 stretch_left;
  bit                 calm;

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result beat ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tilt_angle_vertical_detector_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $realtime, msg);
    end
  endtask

  // CORDIC vectoring: drives v to zero and returns the angle turned through,
  // in 1/65536 degree. Every shift is a floor shift on a signed value.
  function automatic longint cordic_vector(inout longint u, inout longint v);
    longint acc;
    longint du;
    longint dv;
    acc = 0;
    for (int i = 0; i < 20; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u = u + du;
        v = v - dv;
        acc = acc + atan_step[i];
      end else begin
        u = u - du;
        v = v + dv;
        acc = acc - atan_step[i];
      end
    end
    return acc;
  endfunction

  // Tilt of the x axis from straight down, 1/256 degree, 0 to 180 degrees.
  function automatic logic [ANGLE_W-1:0] tilt_q8(input tavd_in_t s);
    longint x;
    longint y;
    longint z;
    longint u;
    longint v;
    longint r;
    longint t;
    longint acc;
    x = longint'(s.accel_x);
    y = longint'(s.accel_y);
    z = longint'(s.accel_z);
    // A sample of all zeros has no direction; the block reports zero.
    if (x == 0 && y == 0 && z == 0) begin
      return '0;
    end
    // First pass: length of the horizontal part, then gain correction.
    u = (y < 0 ? -y : y) * 65536;
    v = z * 65536;
    r = cordic_vector(u, v);
    r = (u * INV_GAIN_Q30_C) >>> 30;
    // Second pass: angle of (x, r). A negative x is first turned by a
    // quarter turn so the vectoring stays in its converging range.
    u = x * 65536;
    v = r;
    acc = 0;
    if (u < 0) begin
      t = u;
      u = v;
      v = -t;
      acc = QUARTER_TURN_Q16;
    end
    acc = acc + cordic_vector(u, v);
    acc = (acc + 128) >>> 8;
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > HALF_TURN_Q8) begin
      acc = HALF_TURN_Q8;
    end
    return acc[ANGLE_W-1:0];
  endfunction

  // Advances the averaging window by one sample and returns the result beat.
  function automatic tavd_out_t predict_reading(input tavd_in_t s);
    tavd_out_t res;
    logic [ANGLE_W-1:0] ang;
    int avg;
    ang = tilt_q8(s);
    hist_sum = hist_sum - int'(angle_hist[hist_slot]) + int'(ang);
    angle_hist[hist_slot] = ang;
    hist_slot = (hist_slot + 1) % HIST_DEPTH;
    if (hist_count < HIST_DEPTH) begin
      hist_count++;
    end
    // Until the window is full the average runs over the samples seen so far.
    avg = (hist_sum + hist_count / 2) / hist_count;
    res.tilt_angle = ang;
    res.average_angle = avg[ANGLE_W-1:0];
    res.vertical = (avg < int'(threshold_q8));
    return res;
  endfunction

  task automatic add_row(input int x, input int y, input int z, input bit has_want,
                         input int tilt, input int avg, input bit vert);
    stim_row_t row;
    row.sample.accel_x = x[15:0];
    row.sample.accel_y = y[15:0];
    row.sample.accel_z = z[15:0];
    row.has_want = has_want;
    row.want.tilt_angle = tilt[15:0];
    row.want.average_angle = avg[15:0];
    row.want.vertical = vert;
    directed_rows.push_back(row);
  endtask

  // Idle cycles before a beat: mostly none or a few, now and then a long one.
  function automatic int pick_gap(input bit no_idle);
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 5);
    end
    return $urandom_range(20, 150);
  endfunction

  function automatic int signed_range(input int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic tavd_in_t make_sample(input sample_style_t sty);
    tavd_in_t s;
    int x;
    int y;
    int z;
    int m;
    x = int'($urandom_range(0, 65535));
    y = int'($urandom_range(0, 65535));
    z = int'($urandom_range(0, 65535));
    case (sty)
      STY_UPRIGHT: begin
        // Close to straight down, so averages fall under low thresholds.
        x = int'($urandom_range(4096, 32767));
        m = x >> $urandom_range(2, 6);
        y = signed_range(m);
        z = signed_range(m);
      end
      STY_INVERTED: begin
        x = -int'($urandom_range(4096, 32768));
        m = ((-x) >> $urandom_range(2, 6));
        y = signed_range(m);
        z = signed_range(m);
      end
      STY_TINY: begin
        x = signed_range(4);
        y = signed_range(4);
        z = signed_range(4);
      end
      STY_ONE_AXIS: begin
        m = $urandom_range(0, 2);
        if (m != 0) x = 0;
        if (m != 1) y = 0;
        if (m != 2) z = 0;
      end
      default: begin
      end
    endcase
    s.accel_x = x[15:0];
    s.accel_y = y[15:0];
    s.accel_z = z[15:0];
    return s;
  endfunction

  // Presents one sample beat and waits for the block to take it. Called and
  // left at a falling edge; valid stays high straight into the next beat
  // when there is no gap.
  task automatic send_sample(input tavd_in_t s, input int gap, input bit has_want,
                             input tavd_out_t want);
    tavd_out_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predicted = predict_reading(s);
    pending_results.push_back(has_want ? want : predicted);
    samples_sent++;
    @(negedge clk);
  endtask

  // Lets every owed result beat arrive, then gives the block time to settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A single-cycle write pulse; the block is idle whenever this is called.
  task automatic write_threshold(input logic [ANGLE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold_q8 = value;
    @(negedge clk);
  endtask

  // Result side: out_ready alternates between open stretches and stalls, with
  // an occasional long stretch that never stalls.
  initial begin
    int hold;
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      hold = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (hold - 1) @(negedge clk);
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Result checker: every accepted result beat is matched, field by field,
  // against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_beat = out_data;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing owed: tilt %0d avg %0d vert %0d",
                                  got_beat.tilt_angle, got_beat.average_angle,
                                  got_beat.vertical));
      end else begin
        want_beat = pending_results.pop_front();
        results_checked++;
        if (got_beat.vertical) vertical_seen++;
        if (got_beat.tilt_angle !== want_beat.tilt_angle) begin
          report_mismatch($sformatf("result %0d tilt_angle got %0d want %0d", results_checked,
                                    got_beat.tilt_angle, want_beat.tilt_angle));
        end
        if (got_beat.average_angle !== want_beat.average_angle) begin
          report_mismatch($sformatf("result %0d average_angle got %0d want %0d",
                                    results_checked, got_beat.average_angle,
                                    want_beat.average_angle));
        end
        if (got_beat.vertical !== want_beat.vertical) begin
          report_mismatch($sformatf("result %0d vertical got %0d want %0d", results_checked,
                                    got_beat.vertical, want_beat.vertical));
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases, each under its own
  // threshold.
  initial begin
    tavd_out_t no_want;
    samples_sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    no_want = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      angle_hist[i] = '0;
    end
    hist_sum = 0;
    hist_count = 0;
    hist_slot = 0;
    threshold_q8 = THRESHOLD_RESET;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows run under the reset threshold of ten degrees. The first
    // three check the empty window: an all-zero sample, a straight-up sample
    // (180 degrees) and the average over a partly filled window.
    add_row(0, 0, 0, 1'b1, 0, 0, 1'b1);
    add_row(-16384, 0, 0, 1'b1, 46080, 23040, 1'b0);
    add_row(0, 0, 0, 1'b1, 0, 15360, 1'b0);
    add_row(32767, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(-32768, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(0, 32767, 0, 1'b0, 0, 0, 1'b0);
    add_row(0, -32768, 0, 1'b0, 0, 0, 1'b0);
    add_row(0, 0, 32767, 1'b0, 0, 0, 1'b0);
    add_row(0, 0, -32768, 1'b0, 0, 0, 1'b0);
    add_row(32767, 32767, 32767, 1'b0, 0, 0, 1'b0);
    add_row(-32768, -32768, -32768, 1'b0, 0, 0, 1'b0);
    add_row(32767, -32768, -32768, 1'b0, 0, 0, 1'b0);
    add_row(-32768, 32767, 32767, 1'b0, 0, 0, 1'b0);
    add_row(-1, -1, -1, 1'b0, 0, 0, 1'b0);
    add_row(1, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(0, -1, 0, 1'b0, 0, 0, 1'b0);
    add_row(0, 0, 1, 1'b0, 0, 0, 1'b0);
    add_row(-1, 0, 0, 1'b0, 0, 0, 1'b0);
    add_row(1, 1, 0, 1'b0, 0, 0, 1'b0);
    add_row(-1, 1, 0, 1'b0, 0, 0, 1'b0);
    add_row(16384, 1, -1, 1'b0, 0, 0, 1'b0);
    add_row(0, 0, 0, 1'b0, 0, 0, 1'b0);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].sample, pick_gap(1'b0), directed_rows[i].has_want,
                  directed_rows[i].want);
    end
    drain_results();

    // Threshold sweep: both register extremes, the top of the angle range,
    // values just above zero and at reset, and one random setting.
    phase_thresholds[0] = '0;
    phase_thresholds[1] = ANGLE_MAX;
    phase_thresholds[2] = 16'hFFFF;
    phase_thresholds[3] = 16'($urandom_range(0, 46080));
    phase_thresholds[4] = 16'd1;
    phase_thresholds[5] = THRESHOLD_RESET;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_threshold(phase_thresholds[p]);
      stretch_left = 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Samples come in stretches of one kind, so the window fills with
        // similar angles and the vertical flag gets to change.
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(8, 30);
          calm = ($urandom_range(0, 3) == 0);
          case ($urandom_range(0, 9))
            0, 1, 2: style = STY_UNIFORM;
            3, 4, 5: style = STY_UPRIGHT;
            6:       style = STY_TINY;
            7, 8:    style = STY_INVERTED;
            default: style = STY_ONE_AXIS;
          endcase
        end
        stretch_left--;
        send_sample(make_sample(style), pick_gap(calm), 1'b0, no_want);
      end
      drain_results();
    end

    $display("Sent %0d sample beats (%0d directed) and checked %0d result beats, %0d vertical.",
             samples_sent, directed_rows.size(), results_checked, vertical_seen);
    $display("Swept %0d threshold settings; %0d mismatches found.", NUM_PHASES + 1,
             error_count);
    if (error_count == 0) begin
      $display("tilt_angle_vertical_detector_tb: done, clean");
    end else begin
      $display("tilt_angle_vertical_detector_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tavd_pkg.sv
rtl/core/tilt_angle_vertical_detector.sv
rtl/core/tavd_checker.sv
dv/tilt_angle_vertical_detector_tb.sv
